// File: design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the sorted priority queue files.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY_DEFAULT = 16;

  localparam logic       OP_ENQUEUE = 1'b0;
  localparam logic       OP_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic signed [31:0] TAKEN_NONE = -32'sd1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] new_item;
    logic signed [31:0] new_priority;
  } spq_req_t;

  typedef struct packed {
    logic signed [31:0] taken_item;
    logic        [1:0]  status;
    logic signed [31:0] head_item;
    logic               is_empty;
    logic        [4:0]  entry_count;
  } spq_rsp_t;

  // One stored entry: priority and item side by side in one RAM word.
  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] item;
  } spq_entry_t;

endpackage

// File: design/spq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue, sorted by signed priority, highest first.
// ----------------------------------------------------------------------------
// Entries live in one RAM, head at address 0, with a single priority compare
// under a small sequencer. A request is taken when start is high and busy is
// low; busy stays high until the result strobe done, which lasts one cycle and
// cannot be held off, so the receiver must take it then. The RAM's one read
// port and its registered read shape each request: an enqueue reads entries
// from the tail and moves each one of lower priority a place toward the tail,
// then writes the new entry; a dequeue takes the head and moves every other
// entry a place toward the head. An empty dequeue or full enqueue writes nothing.
// The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t request,
  output logic              done,
  output spq_pkg::spq_rsp_t result
);

  import spq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD      = 4'd1;
  localparam logic [3:0] S_CMP     = 4'd2;
  localparam logic [3:0] S_INS     = 4'd3;
  localparam logic [3:0] S_DQ_RD0  = 4'd4;
  localparam logic [3:0] S_DQ_TAKE = 4'd5;
  localparam logic [3:0] S_DRD     = 4'd6;
  localparam logic [3:0] S_DWR     = 4'd7;
  localparam logic [3:0] S_HEAD    = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  logic [3:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      k, k_next;
  spq_req_t           req, req_next;
  logic signed [31:0] taken, taken_next;
  logic [1:0]         stat, stat_next;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  spq_entry_t         wdata, rdata;
  logic               new_wins;

  spq_ram #(
    .WIDTH ($bits(spq_entry_t)),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The shared compare: the new entry passes a stored one of lower priority.
  assign new_wins = rdata.prio < req.new_priority;

  always_comb begin
    state_next = state;
    count_next = count;
    k_next     = k;
    req_next   = req;
    taken_next = taken;
    stat_next  = stat;
    we         = 1'b0;
    waddr      = k;
    wdata      = rdata;
    raddr      = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next   = request;
          taken_next = '0;
          stat_next  = ST_DONE;
          k_next     = count[AW-1:0];
          if (request.opcode == OP_DEQUEUE) begin
            if (count == '0) begin
              taken_next = TAKEN_NONE;
              stat_next  = ST_EMPTY;
              state_next = S_RESP;
            end else begin
              state_next = S_DQ_RD0;
            end
          end else if (count == CW'(CAPACITY)) begin
            stat_next  = ST_FULL;
            state_next = S_HEAD;
          end else if (count == '0) begin
            state_next = S_INS;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        raddr      = k - AW'(1);
        state_next = S_CMP;
      end
      S_CMP: begin
        if (new_wins) begin
          we         = 1'b1;
          k_next     = k - AW'(1);
          state_next = (k == AW'(1)) ? S_INS : S_RD;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        we         = 1'b1;
        wdata.prio = req.new_priority;
        wdata.item = req.new_item;
        count_next = count + CW'(1);
        state_next = S_HEAD;
      end
      S_DQ_RD0: begin
        state_next = S_DQ_TAKE;
      end
      S_DQ_TAKE: begin
        taken_next = rdata.item;
        if (count == CW'(1)) begin
          count_next = '0;
          state_next = S_RESP;
        end else begin
          k_next     = AW'(1);
          state_next = S_DRD;
        end
      end
      S_DRD: begin
        raddr      = k;
        state_next = S_DWR;
      end
      S_DWR: begin
        we    = 1'b1;
        waddr = k - AW'(1);
        if (CW'(k) == count - CW'(1)) begin
          count_next = count - CW'(1);
          state_next = S_HEAD;
        end else begin
          k_next     = k + AW'(1);
          state_next = S_DRD;
        end
      end
      S_HEAD: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    k     <= k_next;
    req   <= req_next;
    taken <= taken_next;
    stat  <= stat_next;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  // Head read was issued in the previous cycle whenever the unit is idle or done is high.
  always_comb begin
    result.taken_item  = taken;
    result.status      = stat;
    result.head_item   = (count == '0) ? 32'sd0 : rdata.item;
    result.is_empty    = (count == '0);
    result.entry_count = 5'(count);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy)
    else $error("store written while idle");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result strobe");

  a_count_stable_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> $stable(count))
    else $error("entry count changed with no transfer");

endmodule
